// ===== design/spsn_pkg.sv =====
`timescale 1ns / 1ps
// Package for the SVG path segment normalizer: field widths, command,
// segment kind and status codes, register indexes and the item structs.
// No dependencies.
package spsn_pkg;

    // Field widths
    localparam int COORD_W        = 48;  // input coordinate, signed fixed point
    localparam int OUT_W          = 44;  // output coordinate, signed fixed point
    localparam int LIM_W          = 47;  // coordinate limit register
    localparam int SEG_W          = 17;  // segment counter and limit
    localparam int FRAC_BITS_DFLT = 16;

    // Configuration port geometry (64-bit registers at 8-byte spacing)
    localparam int CFG_DW = 64;
    localparam int CFG_AW = 4;

    // Register reset values
    localparam logic [63:0]      LIM_UNITS   = 64'd100000000;
    localparam logic [SEG_W-1:0] MAX_SEG_RST = 17'd65536;

    // Register indexes (paddr[CFG_AW-1])
    localparam logic REG_COORD_LIMIT  = 1'b0;
    localparam logic REG_MAX_SEGMENTS = 1'b1;

    // Path commands; codes above CMD_SMOOTH are unknown
    typedef enum logic [3:0] {
        CMD_REPEAT = 4'd0,
        CMD_MOVE   = 4'd1,
        CMD_LINE   = 4'd2,
        CMD_HORIZ  = 4'd3,
        CMD_VERT   = 4'd4,
        CMD_CUBIC  = 4'd5,
        CMD_QUAD   = 4'd6,
        CMD_CLOSE  = 4'd7,
        CMD_ARC    = 4'd8,
        CMD_SMOOTH = 4'd9
    } t_cmd;

    // Segment kinds
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_MOVE  = 3'd1;
    localparam logic [2:0] KIND_LINE  = 3'd2;
    localparam logic [2:0] KIND_CUBIC = 3'd3;
    localparam logic [2:0] KIND_CLOSE = 3'd4;

    // Status codes; RANGE and above are sticky
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_CMD   = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_REL_OVF  = 3'd3;
    localparam logic [2:0] ST_TOO_MANY = 3'd4;
    localparam logic [2:0] ST_ARC      = 3'd5;
    localparam logic [2:0] ST_SMOOTH   = 3'd6;
    localparam logic [2:0] ST_UNKNOWN  = 3'd7;

    // One tokenized path command
    typedef struct packed {
        logic                      new_path;
        logic [3:0]                command;
        logic                      relative;
        logic signed [COORD_W-1:0] ctrl1_x;
        logic signed [COORD_W-1:0] ctrl1_y;
        logic signed [COORD_W-1:0] ctrl2_x;
        logic signed [COORD_W-1:0] ctrl2_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } t_cmd_item;

    // One absolute segment
    typedef struct packed {
        logic [2:0]              seg_kind;
        logic signed [OUT_W-1:0] out_c1x;
        logic signed [OUT_W-1:0] out_c1y;
        logic signed [OUT_W-1:0] out_c2x;
        logic signed [OUT_W-1:0] out_c2y;
        logic signed [OUT_W-1:0] out_end_x;
        logic signed [OUT_W-1:0] out_end_y;
        logic [2:0]              status;
    } t_seg_item;

endpackage

// ===== design/svg_path_segment_normalizer.sv =====
`timescale 1ns / 1ps
// SVG path segment normalizer: path state, range and count checks, and the
// quadratic-to-cubic 2/3 scaling pipeline. Depends on spsn_pkg.
//
// The block takes one tokenized path command per item and returns one
// absolute segment (move, line, cubic or close) or an error status. It
// accepts one item every clock cycle while the result side keeps up. The
// path state (current point, subpath start, active command, segment count,
// sticky error) is updated in the single stage right after the input
// register, so back-to-back items see each other's effects with no bubbles.
// The remaining stages carry the 2/3 control-point scaling for quadratics
// (magnitude, two constant-multiply stages for the exact divide by three,
// sum, final add). A stall on the result side backs up through the stages
// and reaches the input only once every stage holds an item.
// Configuration registers: coord_limit at byte 0x0, max_segments at 0x8.
module svg_path_segment_normalizer
    import spsn_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DFLT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command items
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_cmd_item         i_in_item,
    // segment items
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_seg_item         o_out_item,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    localparam logic [LIM_W-1:0] LIM_RST = LIM_W'(LIM_UNITS << FRAC_BITS);

    // Datapath widths
    localparam int SUM_W  = COORD_W + 1;       // coordinate plus offset
    localparam int A_W    = COORD_W;           // magnitude of a difference
    localparam int U_W    = A_W + 1;           // 2*|d| + 1
    localparam int SPLIT  = U_W / 2;           // low part of u, even split point
    localparam int H_W    = U_W - SPLIT;
    localparam int S_W    = H_W + 1;           // high + low part
    localparam int P_W    = H_W + SPLIT;
    localparam int REC_SH = S_W + 1;
    localparam int R_W    = S_W + REC_SH;
    // 2^SPLIT = 1 mod 3 for even SPLIT, so u/3 = H*K_SPLIT + (H+L)/3
    localparam logic [SPLIT-1:0]  K_SPLIT = SPLIT'(((2 ** SPLIT) - 1) / 3);
    // ceil(2^REC_SH / 3): exact floor(s/3) for s < 2^REC_SH
    localparam logic [REC_SH-1:0] K_REC   = REC_SH'(((2 ** REC_SH) / 3) + 1);
    localparam int NSTG = 7;

    // Fields shared by the stage registers from stage 1 through stage 5
    typedef struct packed {
        logic [2:0]            kind;
        logic [2:0]            status;
        logic [OUT_W-1:0]      end_x;
        logic [OUT_W-1:0]      end_y;
        logic [3:0][OUT_W-1:0] base;
    } t_pcom;

    typedef struct packed {
        t_pcom                 com;
        logic [3:0][SUM_W-1:0] d;
    } t_st1;

    typedef struct packed {
        t_pcom               com;
        logic [3:0]          neg;
        logic [3:0][A_W-1:0] mag;
    } t_st2;

    typedef struct packed {
        t_pcom                 com;
        logic [3:0]            neg;
        logic [3:0][OUT_W-1:0] p1;
        logic [3:0][S_W-1:0]   s;
    } t_st3;

    typedef struct packed {
        t_pcom                 com;
        logic [3:0]            neg;
        logic [3:0][OUT_W-1:0] p1;
        logic [3:0][S_W-1:0]   ql;
    } t_st4;

    typedef struct packed {
        t_pcom                 com;
        logic [3:0]            neg;
        logic [3:0][OUT_W-1:0] q;
    } t_st5;

    // Magnitude of a signed value above the limit
    function automatic logic mag_over(input logic signed [SUM_W-1:0] x,
                                      input logic [LIM_W-1:0] lim);
        logic [SUM_W-1:0] m;
        m = x[SUM_W-1] ? SUM_W'(-x) : SUM_W'(x);
        return m > SUM_W'(lim);
    endfunction

    // Configuration registers
    logic [LIM_W-1:0] r_lim;
    logic [SEG_W-1:0] r_max_seg;

    // Path state
    logic signed [COORD_W-1:0] r_cur_x, r_cur_y, r_start_x, r_start_y;
    logic signed [COORD_W-1:0] n_cur_x, n_cur_y, n_start_x, n_start_y;
    logic [3:0]                r_act_cmd, n_act_cmd;
    logic                      r_act_rel, n_act_rel;
    logic [SEG_W-1:0]          r_seen, n_seen;
    logic [2:0]                r_sticky, n_sticky;

    // Pipeline
    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   w_rdy;
    t_cmd_item       r_in;
    t_st1            r_s1, n_s1;
    t_st2            r_s2, n_s2;
    t_st3            r_s3, n_s3;
    t_st4            r_s4, n_s4;
    t_st5            r_s5, n_s5;
    t_seg_item       r_out, n_out;
    logic            w_s1_load;

    // Stage 1 working signals
    logic signed [COORD_W-1:0] b_cx, b_cy, b_sx, b_sy;
    logic [3:0]                b_cmd;
    logic                      b_rel;
    logic [SEG_W-1:0]          b_seen;
    logic [2:0]                b_sticky;
    logic [3:0]                w_cmd;
    logic                      w_rel;
    logic [5:0]                w_use;
    logic signed [COORD_W-1:0] w_v  [6];
    logic signed [SUM_W-1:0]   w_vx [6];
    logic signed [SUM_W-1:0]   w_rr [6];
    logic [5:0]                w_over_v, w_over_r;
    logic                      w_bad_v, w_bad_r;
    logic [2:0]                w_st;
    logic [2:0]                w_kind;

    // Stage 3 and 4 products
    logic [3:0][H_W-1:0]   w_h;
    logic [3:0][SPLIT-1:0] w_l;
    logic [3:0][P_W-1:0]   w_p1;
    logic [3:0][R_W-1:0]   w_p2;

    // ---------------------------------------------------------------
    // Handshake: each stage takes a new item when empty or moving on
    // ---------------------------------------------------------------
    assign w_rdy[NSTG] = !i_out_stall;
    generate
        for (genvar k = 0; k < NSTG; k++) begin : g_rdy
            assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    endgenerate

    assign o_in_stall  = !w_rdy[0];
    assign o_out_valid = r_vld[NSTG-1];
    assign o_out_item  = r_out;
    assign w_s1_load   = w_rdy[1] && r_vld[0];

    // Configuration read side
    assign pready = 1'b1;
    assign prdata = (paddr[CFG_AW-1] == REG_MAX_SEGMENTS) ? CFG_DW'(r_max_seg)
                                                          : CFG_DW'(r_lim);

    // ---------------------------------------------------------------
    // Stage 1: operand selection, range checks, state update
    // ---------------------------------------------------------------
    assign w_v[0] = r_in.ctrl1_x;
    assign w_v[1] = r_in.ctrl1_y;
    assign w_v[2] = r_in.ctrl2_x;
    assign w_v[3] = r_in.ctrl2_y;
    assign w_v[4] = r_in.end_x;
    assign w_v[5] = r_in.end_y;

    // path state as seen by this item, cleared first on a new path
    assign b_cx     = r_in.new_path ? '0 : r_cur_x;
    assign b_cy     = r_in.new_path ? '0 : r_cur_y;
    assign b_sx     = r_in.new_path ? '0 : r_start_x;
    assign b_sy     = r_in.new_path ? '0 : r_start_y;
    assign b_cmd    = r_in.new_path ? CMD_REPEAT : r_act_cmd;
    assign b_rel    = r_in.new_path ? 1'b0 : r_act_rel;
    assign b_seen   = r_in.new_path ? '0 : r_seen;
    assign b_sticky = r_in.new_path ? ST_OK : r_sticky;

    assign w_cmd = (r_in.command != CMD_REPEAT) ? r_in.command  : b_cmd;
    assign w_rel = (r_in.command != CMD_REPEAT) ? r_in.relative : b_rel;

    // absolute operands and their range flags; even lanes x, odd lanes y
    generate
        for (genvar g = 0; g < 6; g++) begin : g_lane
            assign w_vx[g] = SUM_W'(w_v[g]);
            assign w_rr[g] = w_rel ? w_vx[g] + SUM_W'((g % 2 == 1) ? b_cy : b_cx)
                                   : w_vx[g];
            assign w_over_v[g] = mag_over(w_vx[g], r_lim);
            assign w_over_r[g] = mag_over(w_rr[g], r_lim);
        end
    endgenerate

    // operand lanes used: ctrl1 x,y = 0,1; ctrl2 = 2,3; end = 4,5
    always_comb begin
        case (w_cmd)
            CMD_HORIZ: w_use = 6'b01_0000;
            CMD_VERT:  w_use = 6'b10_0000;
            CMD_CUBIC: w_use = 6'b11_1111;
            CMD_QUAD:  w_use = 6'b11_0011;
            CMD_CLOSE: w_use = 6'b00_0000;
            default:   w_use = 6'b11_0000;
        endcase
    end

    assign w_bad_v = |(w_use & w_over_v);
    assign w_bad_r = |(w_use & w_over_r);

    always_comb begin
        n_cur_x   = b_cx;
        n_cur_y   = b_cy;
        n_start_x = b_sx;
        n_start_y = b_sy;
        n_act_cmd = b_cmd;
        n_act_rel = b_rel;
        n_seen    = b_seen;
        n_sticky  = b_sticky;
        w_st      = ST_OK;
        w_kind    = KIND_NONE;
        n_s1      = '0;

        // error priority: sticky, no command, unsupported, range, count
        if (b_sticky != ST_OK) begin
            w_st = b_sticky;
        end else begin
            if (r_in.command != CMD_REPEAT) begin
                n_act_cmd = r_in.command;
                n_act_rel = r_in.relative;
            end
            if (w_cmd == CMD_REPEAT) begin
                w_st = ST_NO_CMD;
            end else if (w_cmd == CMD_ARC) begin
                w_st = ST_ARC;
            end else if (w_cmd == CMD_SMOOTH) begin
                w_st = ST_SMOOTH;
            end else if (w_cmd > CMD_SMOOTH) begin
                w_st = ST_UNKNOWN;
            end else if (w_bad_v) begin
                w_st = ST_RANGE;
            end else if (w_bad_r) begin
                w_st = ST_REL_OVF;
            end else if (b_seen >= r_max_seg) begin
                w_st = ST_TOO_MANY;
            end
            if (w_st >= ST_RANGE) begin
                n_sticky = w_st;
            end
        end

        // segment output and state moves
        if (b_sticky == ST_OK && w_st == ST_OK) begin
            n_seen = b_seen + 1'b1;
            case (w_cmd)
                CMD_MOVE: begin
                    n_cur_x   = w_rr[4][COORD_W-1:0];
                    n_cur_y   = w_rr[5][COORD_W-1:0];
                    n_start_x = w_rr[4][COORD_W-1:0];
                    n_start_y = w_rr[5][COORD_W-1:0];
                    n_act_cmd = CMD_LINE;
                    w_kind    = KIND_MOVE;
                end
                CMD_HORIZ: begin
                    n_cur_x = w_rr[4][COORD_W-1:0];
                    w_kind  = KIND_LINE;
                end
                CMD_VERT: begin
                    n_cur_y = w_rr[5][COORD_W-1:0];
                    w_kind  = KIND_LINE;
                end
                CMD_CUBIC: begin
                    for (int i = 0; i < 4; i++) begin
                        n_s1.com.base[i] = w_rr[i][OUT_W-1:0];
                    end
                    n_cur_x = w_rr[4][COORD_W-1:0];
                    n_cur_y = w_rr[5][COORD_W-1:0];
                    w_kind  = KIND_CUBIC;
                end
                CMD_QUAD: begin
                    // c1 = P + 2/3 (Q - P), c2 = E + 2/3 (Q - E)
                    n_s1.com.base[0] = b_cx[OUT_W-1:0];
                    n_s1.com.base[1] = b_cy[OUT_W-1:0];
                    n_s1.com.base[2] = w_rr[4][OUT_W-1:0];
                    n_s1.com.base[3] = w_rr[5][OUT_W-1:0];
                    n_s1.d[0] = w_rel ? w_vx[0] : w_vx[0] - SUM_W'(b_cx);
                    n_s1.d[1] = w_rel ? w_vx[1] : w_vx[1] - SUM_W'(b_cy);
                    n_s1.d[2] = w_vx[0] - w_vx[4];
                    n_s1.d[3] = w_vx[1] - w_vx[5];
                    n_cur_x   = w_rr[4][COORD_W-1:0];
                    n_cur_y   = w_rr[5][COORD_W-1:0];
                    w_kind    = KIND_CUBIC;
                end
                CMD_CLOSE: begin
                    n_cur_x   = b_sx;
                    n_cur_y   = b_sy;
                    n_act_cmd = CMD_REPEAT;
                    w_kind    = KIND_CLOSE;
                end
                default: begin
                    n_cur_x = w_rr[4][COORD_W-1:0];
                    n_cur_y = w_rr[5][COORD_W-1:0];
                    w_kind  = KIND_LINE;
                end
            endcase
            n_s1.com.end_x = n_cur_x[OUT_W-1:0];
            n_s1.com.end_y = n_cur_y[OUT_W-1:0];
        end
        n_s1.com.kind   = w_kind;
        n_s1.com.status = w_st;
    end

    // ---------------------------------------------------------------
    // Stages 2..6: t = 2d, result base + sign(t) * floor((|t| + 1) / 3)
    // ---------------------------------------------------------------
    always_comb begin
        // stage 2: magnitude and sign
        n_s2.com = r_s1.com;
        for (int i = 0; i < 4; i++) begin
            n_s2.neg[i] = r_s1.d[i][SUM_W-1];
            n_s2.mag[i] = r_s1.d[i][SUM_W-1] ? A_W'(-$signed(r_s1.d[i]))
                                              : A_W'(r_s1.d[i]);
        end

        // stage 3: u = {|d|, 1} split into high and low parts
        n_s3.com = r_s2.com;
        n_s3.neg = r_s2.neg;
        for (int i = 0; i < 4; i++) begin
            w_h[i]     = r_s2.mag[i][A_W-1 -: H_W];
            w_l[i]     = {r_s2.mag[i][SPLIT-2:0], 1'b1};
            w_p1[i]    = P_W'(w_h[i]) * P_W'(K_SPLIT);
            n_s3.p1[i] = w_p1[i][OUT_W-1:0];
            n_s3.s[i]  = S_W'(w_h[i]) + S_W'(w_l[i]);
        end

        // stage 4: floor(s/3) by reciprocal
        n_s4.com = r_s3.com;
        n_s4.neg = r_s3.neg;
        n_s4.p1  = r_s3.p1;
        for (int i = 0; i < 4; i++) begin
            w_p2[i]    = R_W'(r_s3.s[i]) * R_W'(K_REC);
            n_s4.ql[i] = w_p2[i][R_W-1:REC_SH];
        end

        // stage 5: quotient, kept to output width
        n_s5.com = r_s4.com;
        n_s5.neg = r_s4.neg;
        for (int i = 0; i < 4; i++) begin
            n_s5.q[i] = r_s4.p1[i] + OUT_W'(r_s4.ql[i]);
        end

        // stage 6: apply to base, form the segment item
        n_out.seg_kind  = r_s5.com.kind;
        n_out.out_c1x   = r_s5.neg[0] ? r_s5.com.base[0] - r_s5.q[0]
                                      : r_s5.com.base[0] + r_s5.q[0];
        n_out.out_c1y   = r_s5.neg[1] ? r_s5.com.base[1] - r_s5.q[1]
                                      : r_s5.com.base[1] + r_s5.q[1];
        n_out.out_c2x   = r_s5.neg[2] ? r_s5.com.base[2] - r_s5.q[2]
                                      : r_s5.com.base[2] + r_s5.q[2];
        n_out.out_c2y   = r_s5.neg[3] ? r_s5.com.base[3] - r_s5.q[3]
                                      : r_s5.com.base[3] + r_s5.q[3];
        n_out.out_end_x = r_s5.com.end_x;
        n_out.out_end_y = r_s5.com.end_y;
        n_out.status    = r_s5.com.status;
    end

    // ---------------------------------------------------------------
    // Control state, path state and configuration
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_start_x <= '0;
            r_start_y <= '0;
            r_act_cmd <= CMD_REPEAT;
            r_act_rel <= 1'b0;
            r_seen    <= '0;
            r_sticky  <= ST_OK;
            r_lim     <= LIM_RST;
            r_max_seg <= MAX_SEG_RST;
        end else begin
            // valid bits follow the items
            if (w_rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end

            if (w_s1_load) begin
                r_cur_x   <= n_cur_x;
                r_cur_y   <= n_cur_y;
                r_start_x <= n_start_x;
                r_start_y <= n_start_y;
                r_act_cmd <= n_act_cmd;
                r_act_rel <= n_act_rel;
                r_seen    <= n_seen;
                r_sticky  <= n_sticky;
            end

            if (psel && penable && pwrite && pready) begin
                unique case (paddr[CFG_AW-1])
                    REG_COORD_LIMIT:  r_lim     <= pwdata[LIM_W-1:0];
                    REG_MAX_SEGMENTS: r_max_seg <= pwdata[SEG_W-1:0];
                endcase
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_in <= i_in_item;
        end
        if (w_rdy[1]) begin
            r_s1 <= n_s1;
        end
        if (w_rdy[2]) begin
            r_s2 <= n_s2;
        end
        if (w_rdy[3]) begin
            r_s3 <= n_s3;
        end
        if (w_rdy[4]) begin
            r_s4 <= n_s4;
        end
        if (w_rdy[5]) begin
            r_s5 <= n_s5;
        end
        if (w_rdy[6]) begin
            r_out <= n_out;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // a blocked path moves neither point nor count
    a_sticky_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_load && !r_in.new_path && r_sticky != ST_OK) |=>
        ($stable(r_cur_x) && $stable(r_cur_y) && $stable(r_seen)))
        else $error("path state changed while error is sticky");

    // only a good segment advances the count
    a_count_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_load && w_st != ST_OK) |=> (r_seen == '0 || $stable(r_seen)))
        else $error("segment count advanced on an error item");

    // close returns to the subpath start
    a_close_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_load && w_st == ST_OK && w_kind == KIND_CLOSE) |=>
        (r_cur_x == r_start_x && r_cur_y == r_start_y))
        else $error("close left current point off subpath start");

    // a sticky error class is recorded as reported
    a_sticky_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_load && w_st >= ST_RANGE) |=> (r_sticky == $past(w_st)))
        else $error("sticky error not recorded");

endmodule
